@@ hdl/spc_pkg.sv @@
`default_nettype none

package spc_pkg;

    // Longest path accepted, not counting the terminating zero byte.
    localparam int MaxPathLen = 128;
    localparam int CountW     = 8;

    // Folder names that the first component must match exactly.
    localparam int NameCount  = 7;
    localparam int NameMaxLen = 10;
    localparam int NameIdxW   = 4;

    localparam logic [NameIdxW-1:0] NameLen [NameCount] =
        '{4'd5, 4'd10, 4'd8, 4'd6, 4'd7, 4'd7, 4'd4};

    localparam logic [7:0] NameText [NameCount][NameMaxLen] = '{
        '{"M", "u", "s", "i", "c", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"R", "e", "c", "o", "r", "d", "i", "n", "g", "s"},
        '{"P", "i", "c", "t", "u", "r", "e", "s", 8'h00, 8'h00},
        '{"T", "h", "e", "m", "e", "s", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"U", "p", "d", "a", "t", "e", "s", 8'h00, 8'h00, 8'h00},
        '{"B", "a", "c", "k", "u", "p", "s", 8'h00, 8'h00, 8'h00},
        '{"L", "o", "g", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // Byte codes with a meaning of their own.
    localparam logic [7:0] CharNul       = 8'h00;
    localparam logic [7:0] CharCtrlLimit = 8'h20;
    localparam logic [7:0] CharBackslash = 8'h5C;
    localparam logic [7:0] CharColon     = 8'h3A;
    localparam logic [7:0] CharSlash     = 8'h2F;
    localparam logic [7:0] CharDot       = 8'h2E;

    // Component length classes: empty, one, two, three or more bytes.
    localparam logic [1:0] LenClassEmpty = 2'd0;
    localparam logic [1:0] LenClassMany  = 2'd3;

    typedef struct packed {
        logic valid;
        logic safe;
    } spc_verdict_t;

endpackage

`default_nettype wire

@@ hdl/spc_core.sv @@
`default_nettype none

// Running path state and the verdict logic for one byte per step.
module spc_core
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          path_char,
    output spc_pkg::spc_verdict_t    verdict
);

    logic [spc_pkg::CountW-1:0]    char_count_reg, char_count_next;
    logic [spc_pkg::NameCount-1:0] mask_reg, mask_next;
    logic                          first_reg, first_next;
    logic [1:0]                    len_class_reg, len_class_next;
    logic                          all_dots_reg, all_dots_next;
    logic                          rejected_reg, rejected_next;

    logic [spc_pkg::NameCount-1:0] len_keep;
    logic [spc_pkg::NameCount-1:0] char_keep;
    logic [spc_pkg::NameIdxW-1:0]  pos_idx;
    logic [spc_pkg::NameCount-1:0] final_mask;
    logic                          comp_bad;
    logic                          is_end;

    assign is_end  = (path_char == spc_pkg::CharNul);
    assign pos_idx = (char_count_reg < spc_pkg::CountW'(spc_pkg::NameMaxLen))
                   ? char_count_reg[spc_pkg::NameIdxW-1:0] : '0;

    always_comb
    begin
        for (int i = 0; i < spc_pkg::NameCount; i++)
        begin
            len_keep[i]  = (char_count_reg ==
                            spc_pkg::CountW'(spc_pkg::NameLen[i]));
            char_keep[i] = (char_count_reg <
                            spc_pkg::CountW'(spc_pkg::NameLen[i]))
                        && (spc_pkg::NameText[i][pos_idx] == path_char);
        end
    end

    // An empty, "." or ".." component is not allowed.
    assign comp_bad = (len_class_reg == spc_pkg::LenClassEmpty)
                   || ((len_class_reg != spc_pkg::LenClassMany) && all_dots_reg);

    assign final_mask = first_reg ? (mask_reg & len_keep) : mask_reg;

    assign verdict.valid = step && is_end;
    assign verdict.safe  = !rejected_reg && !comp_bad && (|final_mask);

    always_comb
    begin
        char_count_next = char_count_reg;
        mask_next       = mask_reg;
        first_next      = first_reg;
        len_class_next  = len_class_reg;
        all_dots_next   = all_dots_reg;
        rejected_next   = rejected_reg;
        if (step)
        begin
            if (is_end)
            begin
                char_count_next = '0;
                mask_next       = '1;
                first_next      = 1'b1;
                len_class_next  = spc_pkg::LenClassEmpty;
                all_dots_next   = 1'b1;
                rejected_next   = 1'b0;
            end
            else
            begin
                if (char_count_reg >= spc_pkg::CountW'(spc_pkg::MaxPathLen))
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    char_count_next = char_count_reg + 1'b1;
                end

                if ((path_char == spc_pkg::CharBackslash)
                    || (path_char == spc_pkg::CharColon)
                    || (path_char < spc_pkg::CharCtrlLimit))
                begin
                    rejected_next = 1'b1;
                end

                if (path_char == spc_pkg::CharSlash)
                begin
                    if (comp_bad)
                    begin
                        rejected_next = 1'b1;
                    end
                    if (first_reg)
                    begin
                        mask_next  = mask_reg & len_keep;
                        first_next = 1'b0;
                    end
                    len_class_next = spc_pkg::LenClassEmpty;
                    all_dots_next  = 1'b1;
                end
                else
                begin
                    if (first_reg)
                    begin
                        mask_next = mask_reg & char_keep;
                    end
                    if (len_class_reg != spc_pkg::LenClassMany)
                    begin
                        len_class_next = len_class_reg + 1'b1;
                    end
                    if (path_char != spc_pkg::CharDot)
                    begin
                        all_dots_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg <= '0;
            mask_reg       <= '1;
            first_reg      <= 1'b1;
            len_class_reg  <= spc_pkg::LenClassEmpty;
            all_dots_reg   <= 1'b1;
            rejected_reg   <= 1'b0;
        end
        else
        begin
            char_count_reg <= char_count_next;
            mask_reg       <= mask_next;
            first_reg      <= first_next;
            len_class_reg  <= len_class_next;
            all_dots_reg   <= all_dots_next;
            rejected_reg   <= rejected_next;
        end
    end

    // The byte count never passes the length limit.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= spc_pkg::CountW'(spc_pkg::MaxPathLen))
        else $error("spc_core: byte count beyond limit");

    // After a verdict the path state starts over.
    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |=> (char_count_reg == '0) && (&mask_reg) && first_reg
                          && !rejected_reg)
        else $error("spc_core: state not cleared after verdict");

    // A rejected path stays rejected until its verdict is given.
    a_reject_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (rejected_reg && !verdict.valid) |=> rejected_reg)
        else $error("spc_core: reject flag dropped inside a path");

endmodule

`default_nettype wire

@@ hdl/safe_relative_path_checker.sv @@
// Safe relative path checker.
// The slave channel (s_tvalid, s_tready, s_tdata) takes a relative path one
// byte per beat; a zero byte ends the path. Each path gives exactly one beat
// on the master channel (m_tvalid, m_tready, m_tdata) whose bit 0 is 1 when
// the path is safe: its first component is one of the seven allowed folder
// names, it is no longer than the length limit, it holds no backslash, colon
// or control byte, and no component is empty, "." or "..".
// A byte is captured in an input register, and in the following cycle the
// running path state is updated by short logic; on the terminating byte the
// verdict is loaded into the output register. m_tvalid therefore rises once
// the terminating byte has passed through the input register and the
// output register.
// One byte is accepted every cycle except while a terminating byte waits
// for the output register. Only a terminating byte needs room in the
// output register, so when the receiver holds m_tready low with a verdict
// pending, path bytes still flow until the next terminating byte reaches
// the input register, and s_tready drops until the pending verdict is taken.
// rst_n clears the path state and both valid flags; no verdict is pending
// after reset.
`default_nettype none

module safe_relative_path_checker
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] path_char
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] path_safe, [7:1] zero
);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_char_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_safe_reg;
    logic                  advance;
    spc_pkg::spc_verdict_t verdict;

    // A path byte always moves on; a terminating byte needs a free output.
    assign advance = in_valid_reg
                  && ((in_char_reg != spc_pkg::CharNul) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    spc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .path_char (in_char_reg),
        .verdict   (verdict)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end

        out_valid_next = out_valid_reg;
        if (verdict.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
        end
        if (verdict.valid)
        begin
            out_safe_reg <= verdict.safe;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_safe_reg};

    // Backpressure only comes from a terminating byte blocked by a pending verdict.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && (in_char_reg == spc_pkg::CharNul)
                      && out_valid_reg && !m_tready)
        else $error("safe_relative_path_checker: unexpected stall");

    // A verdict never overwrites one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> !out_valid_reg || m_tready)
        else $error("safe_relative_path_checker: verdict overwritten");

    // The output register is loaded only from a terminating byte.
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |->
            $past(in_valid_reg && (in_char_reg == spc_pkg::CharNul)))
        else $error("safe_relative_path_checker: verdict without terminator");

endmodule

`default_nettype wire
